// File: hw/rtl/trg_pkg.sv
package trg_pkg;

   localparam int DefMaxPaneCount = 32;

   // field and register widths
   localparam int PCNT_W     = 6;
   localparam int IDX_W      = 5;
   localparam int OUT_W      = 16;
   localparam int MODE_W     = 3;
   localparam int COORD_W    = 14;
   localparam int GAP_W      = 10;
   localparam int RATIO_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // internal datapath widths
   localparam int VAL_W     = 24;
   localparam int CNT_W     = 7;
   localparam int DIV_NW    = 18;
   localparam int DIV_CNT_W = 5;
   localparam int PROD_W    = 2 * RATIO_W;

   // minimum sizes
   localparam int MIN_PANE   = 1;
   localparam int MIN_SIDE_W = 4;

   typedef logic signed [VAL_W-1:0]  val_type;
   typedef logic signed [DIV_NW-1:0] dnum_type;

   localparam logic [MODE_W-1:0] MODE_HALVING = 3'd0;
   localparam logic [MODE_W-1:0] MODE_COLUMNS = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ROWS    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_THREE   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MONOCLE = 3'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE, CSR_AREA_X, CSR_AREA_Y, CSR_AREA_W, CSR_AREA_H, CSR_GAP, CSR_RATIO
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_HALVING, KIND_COLUMNS, KIND_ROWS, KIND_THREE, KIND_MONOCLE
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_CENTER, ST_DIV_A, ST_DIV_B, ST_EMIT
   } state_type;

   typedef struct packed {
      logic             start;
      dnum_type         num;
      logic [CNT_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic     done;
      dnum_type quo;
   } div_rsp_type;

endpackage

// File: hw/rtl/trg_channel_if.sv
interface trg_req_if import trg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PCNT_W-1:0] pane_count;

   modport source(output valid, output pane_count, input ready);
   modport sink(input valid, input pane_count, output ready);
endinterface

interface trg_rsp_if import trg_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        pane_index;
   logic signed [OUT_W-1:0] pane_x;
   logic signed [OUT_W-1:0] pane_y;
   logic signed [OUT_W-1:0] pane_w;
   logic signed [OUT_W-1:0] pane_h;
   logic                    last_pane;

   modport source(output valid, output pane_index, output pane_x, output pane_y,
                  output pane_w, output pane_h, output last_pane, input ready);
   modport sink(input valid, input pane_index, input pane_x, input pane_y,
                input pane_w, input pane_h, input last_pane, output ready);
endinterface

// File: hw/rtl/trg_divider.sv
module trg_divider import trg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [CNT_W:0]       trial;
   logic                 fits;

   // one quotient bit per cycle, restoring, on magnitudes
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_NW-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = div_req.den;
         neg_in  = div_req.num[DIV_NW-1];
         quo_in  = div_req.num[DIV_NW-1] ? -div_req.num : div_req.num;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_NW-2:0], fits};
         rem_in = fits ? CNT_W'(trial - {1'b0, den_ff}) : trial[CNT_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // truncate toward zero: restore the sign on the magnitude quotient
   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = neg_ff ? -dnum_type'(quo_ff) : dnum_type'(quo_ff);

endmodule

// File: hw/rtl/tiling_rect_generator_unit.sv
// Tiling rectangle generator.
// req_bus carries a pane count; rsp_bus returns one rectangle beat per pane,
// in pane order, with last_pane set on the final one. A count of zero is
// taken and gives no beats; counts above MAX_PANE_COUNT are saturated.
// Layout, area, gap and split ratio come from the csr_ port (index, data,
// write enable), written only while the block is idle; the block does not enforce this.
// Halving and monocle need no division; columns and rows wait for one pass
// of the shared radix-2 divider and three-column for two passes; the divider
// makes one quotient bit per cycle over 18 bits. After that one beat
// leaves per cycle while the receiver does not stall. req_bus.ready is
// high only while no item is in work; the last beat may still wait in the
// output register while the next count is taken. When the receiver stalls,
// the output register holds its beat and the sequencer waits.
// Reset (synchronous, active high) restores the register defaults (halving,
// 1920 by 1080 at the origin, no gap, ratio one half) and drops any beat.
module tiling_rect_generator_unit import trg_pkg::*; #(
   parameter int MAX_PANE_COUNT = DefMaxPaneCount
) (
   input  logic                  clock,
   input  logic                  reset,
   trg_req_if.sink               req_bus,
   trg_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam val_type ONE_V  = val_type'(MIN_PANE);
   localparam val_type SIDE_V = val_type'(MIN_SIDE_W);

   function automatic val_type half_tz(val_type v);
      half_tz = (v + val_type'(v[VAL_W-1])) >>> 1;
   endfunction

   // configuration registers
   logic [MODE_W-1:0]  mode_ff;
   logic [COORD_W-1:0] ax_ff, ay_ff, aw_ff, ah_ff;
   logic [GAP_W-1:0]   gap_ff;
   logic [RATIO_W-1:0] ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_HALVING;
         ax_ff    <= '0;
         ay_ff    <= '0;
         aw_ff    <= COORD_W'(1920);
         ah_ff    <= COORD_W'(1080);
         gap_ff   <= '0;
         ratio_ff <= RATIO_W'(32768);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE:   mode_ff  <= csr_wdata[MODE_W-1:0];
            CSR_AREA_X: ax_ff    <= csr_wdata[COORD_W-1:0];
            CSR_AREA_Y: ay_ff    <= csr_wdata[COORD_W-1:0];
            CSR_AREA_W: aw_ff    <= csr_wdata[COORD_W-1:0];
            CSR_AREA_H: ah_ff    <= csr_wdata[COORD_W-1:0];
            CSR_GAP:    gap_ff   <= csr_wdata[GAP_W-1:0];
            CSR_RATIO:  ratio_ff <= csr_wdata[RATIO_W-1:0];
            default:    ;
         endcase
      end
   end

   val_type ax_v, ay_v, aw_v, ah_v, g_v, g2_v;
   assign ax_v = val_type'(ax_ff);
   assign ay_v = val_type'(ay_ff);
   assign aw_v = val_type'(aw_ff);
   assign ah_v = val_type'(ah_ff);
   assign g_v  = val_type'(gap_ff);
   assign g2_v = g_v <<< 1;

   // sequencer and work registers
   state_type            state_ff, state_in;
   kind_type             kind_ff, kind_in;
   logic                 ovr_ff, ovr_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     rn_ff, rn_in, ln_ff, ln_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic                 pneg_ff, pneg_in;
   dnum_type             num_a_ff, num_a_in, num_b_ff, num_b_in;
   val_type              cw_ff, cw_in, sw_ff, sw_in;
   val_type              qa_ff, qa_in, qb_ff, qb_in;
   val_type              bx_ff, bx_in, by_ff, by_in, bw_ff, bw_in, bh_ff, bh_in;
   val_type              yr_ff, yr_in, yl_ff, yl_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic [OUT_W-1:0]     rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [OUT_W-1:0]     rsp_w_ff, rsp_w_in, rsp_h_ff, rsp_h_in;
   logic                 rsp_last_ff, rsp_last_in;

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   trg_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic [CNT_W-1:0]       cnt_sat, sn, rn_c, ln_c, k_a;
   logic [GAP_W+CNT_W-1:0] gk_a, gk_b;
   val_type                base_a, rv, scaled, hi_lw, lw_c, cw_c, sw_c, q_v, q_cl;
   logic [RATIO_W-1:0]     rmag;
   logic                   load, last;
   val_type                px, py, pw, ph, lw, rw;

   assign cnt_sat = (CNT_W'(req_bus.pane_count) > CNT_W'(MAX_PANE_COUNT))
                  ? CNT_W'(MAX_PANE_COUNT) : CNT_W'(req_bus.pane_count);

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign load          = !rsp_valid_ff || rsp_bus.ready;
   assign last          = (idx_ff == n_ff - 1'b1);

   // stack counts and divider operands
   always_comb begin
      sn     = n_ff - 1'b1;
      rn_c   = n_ff >> 1;
      ln_c   = sn - rn_c;
      k_a    = (kind_ff == KIND_THREE) ? rn_c : n_ff;
      gk_a   = gap_ff * (k_a - 1'b1);
      gk_b   = gap_ff * (ln_c - 1'b1);
      base_a = (kind_ff == KIND_COLUMNS) ? aw_v : ah_v;
      rv     = ovr_ff ? (aw_v - g_v) : (aw_v - g2_v);
      rmag   = rv[VAL_W-1] ? RATIO_W'(-rv) : RATIO_W'(rv);
   end

   // centre width and side width from the ratio product
   always_comb begin
      scaled = pneg_ff ? -val_type'(prod_ff[PROD_W-1:RATIO_W])
                       : val_type'(prod_ff[PROD_W-1:RATIO_W]);
      hi_lw  = aw_v - g_v - ONE_V;
      lw_c   = (scaled < ONE_V) ? ONE_V : scaled;
      if (lw_c > hi_lw) lw_c = hi_lw;
      cw_c   = (scaled < SIDE_V) ? SIDE_V : scaled;
      sw_c   = half_tz(aw_v - cw_c - g2_v);
      if (sw_c < SIDE_V) begin
         sw_c = SIDE_V;
         cw_c = aw_v - (SIDE_V <<< 1) - g2_v;
      end
   end

   assign q_v  = val_type'(div_rsp.quo);
   assign q_cl = (q_v < ONE_V) ? ONE_V : q_v;

   // divider requests: first stack, then left stack in three-column mode
   always_comb begin
      div_req.start = ((state_ff == ST_CENTER) && (kind_ff == KIND_COLUMNS ||
                       kind_ff == KIND_ROWS || kind_ff == KIND_THREE)) ||
                      ((state_ff == ST_DIV_A) && div_rsp.done && kind_ff == KIND_THREE);
      div_req.num   = (state_ff == ST_DIV_A) ? num_b_ff : num_a_ff;
      div_req.den   = (state_ff == ST_DIV_A) ? ln_ff
                    : ((kind_ff == KIND_THREE) ? rn_ff : n_ff);
   end

   // next state, work registers and the pane under emission
   always_comb begin
      state_in = state_ff;  kind_in = kind_ff;  ovr_in = ovr_ff;
      n_in = n_ff;  idx_in = idx_ff;  rn_in = rn_ff;  ln_in = ln_ff;
      prod_in = prod_ff;  pneg_in = pneg_ff;
      num_a_in = num_a_ff;  num_b_in = num_b_ff;
      cw_in = cw_ff;  sw_in = sw_ff;  qa_in = qa_ff;  qb_in = qb_ff;
      bx_in = bx_ff;  by_in = by_ff;  bw_in = bw_ff;  bh_in = bh_ff;
      yr_in = yr_ff;  yl_in = yl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_idx_in = rsp_idx_ff;  rsp_last_in = rsp_last_ff;
      rsp_x_in = rsp_x_ff;  rsp_y_in = rsp_y_ff;
      rsp_w_in = rsp_w_ff;  rsp_h_in = rsp_h_ff;
      px = bx_ff;  py = by_ff;  pw = bw_ff;  ph = bh_ff;
      lw = '0;  rw = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid && cnt_sat != '0) begin
               n_in   = cnt_sat;
               ovr_in = 1'b0;
               case (mode_ff)
                  MODE_COLUMNS: kind_in = KIND_COLUMNS;
                  MODE_ROWS:    kind_in = KIND_ROWS;
                  MODE_MONOCLE: kind_in = KIND_MONOCLE;
                  MODE_THREE: begin
                     if (cnt_sat == CNT_W'(1)) begin
                        kind_in = KIND_MONOCLE;
                     end else if (cnt_sat == CNT_W'(2)) begin
                        kind_in = KIND_HALVING;
                        ovr_in  = 1'b1;
                     end else begin
                        kind_in = KIND_THREE;
                     end
                  end
                  default:      kind_in = KIND_HALVING;
               endcase
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            prod_in  = rmag * ratio_ff;
            pneg_in  = rv[VAL_W-1];
            rn_in    = rn_c;
            ln_in    = ln_c;
            num_a_in = DIV_NW'(base_a - val_type'(gk_a));
            num_b_in = DIV_NW'(ah_v - val_type'(gk_b));
            idx_in   = '0;
            bx_in    = ax_v;
            by_in    = ay_v;
            bw_in    = aw_v;
            bh_in    = ah_v;
            yr_in    = ay_v;
            yl_in    = ay_v;
            state_in = ST_CENTER;
         end
         ST_CENTER: begin
            cw_in    = ovr_ff ? lw_c : cw_c;
            sw_in    = sw_c;
            state_in = div_req.start ? ST_DIV_A : ST_EMIT;
         end
         ST_DIV_A: begin
            if (div_rsp.done) begin
               qa_in    = q_cl;
               state_in = (kind_ff == KIND_THREE) ? ST_DIV_B : ST_EMIT;
            end
         end
         ST_DIV_B: begin
            if (div_rsp.done) begin
               qb_in    = q_cl;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            case (kind_ff)
               KIND_COLUMNS: begin
                  px = bx_ff;  py = ay_v;  ph = ah_v;
                  pw = last ? (ax_v + aw_v - bx_ff) : qa_ff;
                  bx_in = bx_ff + qa_ff + g_v;
               end
               KIND_ROWS: begin
                  px = ax_v;  py = by_ff;  pw = aw_v;
                  ph = last ? (ay_v + ah_v - by_ff) : qa_ff;
                  by_in = by_ff + qa_ff + g_v;
               end
               KIND_MONOCLE: begin
                  px = ax_v;  py = ay_v;  pw = aw_v;  ph = ah_v;
               end
               KIND_THREE: begin
                  if (idx_ff == '0) begin
                     px = ax_v + sw_ff + g_v;  py = ay_v;  pw = cw_ff;  ph = ah_v;
                  end else if (idx_ff[0]) begin
                     // right stack
                     px = ax_v + sw_ff + g_v + cw_ff + g_v;
                     py = yr_ff;  pw = sw_ff;
                     ph = (rn_ff == CNT_W'(1)) ? (ay_v + ah_v - yr_ff) : qa_ff;
                     yr_in = yr_ff + qa_ff + g_v;
                     rn_in = rn_ff - 1'b1;
                  end else begin
                     // left stack
                     px = ax_v;  py = yl_ff;  pw = sw_ff;
                     ph = (ln_ff == CNT_W'(1)) ? (ay_v + ah_v - yl_ff) : qb_ff;
                     yl_in = yl_ff + qb_ff + g_v;
                     ln_in = ln_ff - 1'b1;
                  end
               end
               default: begin
                  // alternating halving; the last pane takes what is left
                  if (!last && (ovr_ff || !idx_ff[0])) begin
                     lw = ovr_ff ? cw_ff : half_tz(bw_ff - g_v);
                     if (lw < ONE_V) lw = ONE_V;
                     rw = bw_ff - lw - g_v;
                     if (rw < ONE_V) begin
                        rw = ONE_V;
                        lw = bw_ff - ONE_V - g_v;
                     end
                     pw    = lw;
                     bx_in = bx_ff + lw + g_v;
                     bw_in = rw;
                  end else if (!last) begin
                     lw = half_tz(bh_ff - g_v);
                     if (lw < ONE_V) lw = ONE_V;
                     rw = bh_ff - lw - g_v;
                     if (rw < ONE_V) begin
                        rw = ONE_V;
                        lw = bh_ff - ONE_V - g_v;
                     end
                     ph    = lw;
                     by_in = by_ff + lw + g_v;
                     bh_in = rw;
                  end
               end
            endcase
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = idx_ff[IDX_W-1:0];
               rsp_last_in  = last;
               rsp_x_in     = px[OUT_W-1:0];
               rsp_y_in     = py[OUT_W-1:0];
               rsp_w_in     = pw[OUT_W-1:0];
               rsp_h_in     = ph[OUT_W-1:0];
               idx_in       = idx_ff + 1'b1;
               if (last) state_in = ST_IDLE;
            end else begin
               // hold the cursors until the beat can be loaded
               bx_in = bx_ff;  by_in = by_ff;  bw_in = bw_ff;  bh_in = bh_ff;
               yr_in = yr_ff;  yl_in = yl_ff;  rn_in = rn_ff;  ln_in = ln_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff  <= kind_in;   ovr_ff   <= ovr_in;
      n_ff     <= n_in;      idx_ff   <= idx_in;
      rn_ff    <= rn_in;     ln_ff    <= ln_in;
      prod_ff  <= prod_in;   pneg_ff  <= pneg_in;
      num_a_ff <= num_a_in;  num_b_ff <= num_b_in;
      cw_ff    <= cw_in;     sw_ff    <= sw_in;
      qa_ff    <= qa_in;     qb_ff    <= qb_in;
      bx_ff    <= bx_in;     by_ff    <= by_in;
      bw_ff    <= bw_in;     bh_ff    <= bh_in;
      yr_ff    <= yr_in;     yl_ff    <= yl_in;
      rsp_idx_ff  <= rsp_idx_in;  rsp_last_ff <= rsp_last_in;
      rsp_x_ff    <= rsp_x_in;    rsp_y_ff    <= rsp_y_in;
      rsp_w_ff    <= rsp_w_in;    rsp_h_ff    <= rsp_h_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.pane_index = rsp_idx_ff;
   assign rsp_bus.pane_x     = rsp_x_ff;
   assign rsp_bus.pane_y     = rsp_y_ff;
   assign rsp_bus.pane_w     = rsp_w_ff;
   assign rsp_bus.pane_h     = rsp_h_ff;
   assign rsp_bus.last_pane  = rsp_last_ff;

endmodule

// File: hw/rtl/trg_checker.sv
module trg_checker import trg_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [PCNT_W-1:0] req_count,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [IDX_W-1:0]  rsp_index,
   input logic              rsp_last
);

   // a nonzero count keeps the block busy in the next cycle
   a_busy_after_count: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_count != '0 |=> !req_ready)
      else $error("count taken but block still ready");

   // the next pane follows at once a beat that is not the last
   a_next_pane_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap in the middle of an item");

   // pane indexes step up by one between beats of one item
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last ##1 rsp_valid |->
      rsp_index == $past(rsp_index) + 1'b1)
      else $error("pane index skipped");

   // a stalled beat keeps its index
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index))
      else $error("stalled beat changed");

endmodule

bind tiling_rect_generator_unit trg_checker u_trg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_count (req_bus.pane_count),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_index (rsp_bus.pane_index),
   .rsp_last  (rsp_bus.last_pane)
);
